[hdl/aging_hash_connection_table_unit_assert.svh]
// Assertion macros for the connection table unit
`ifndef AGING_HASH_CONNECTION_TABLE_UNIT_ASSERT_SVH
`define AGING_HASH_CONNECTION_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define AHCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AHCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/ahct_pkg.sv]
// Shared types and constants of the connection table unit
`default_nettype none
package ahct_pkg;

    localparam int KEY_ADDR_W = 32;
    localparam int KEY_PORT_W = 16;
    localparam int SEQ_W      = 32;
    localparam int TICK_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int STATUS_W   = 2;
    localparam int MOD_CNT_W  = 1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [KEY_ADDR_W-1:0] addr;
        logic [KEY_PORT_W-1:0] port;
        logic [SEQ_W-1:0]      seq;
        logic [TICK_W-1:0]     stamp;
    } entry_t;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic mod_step;
        logic seed;
        logic probe;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic probe_done;
    } dp_stat_t;

endpackage
`default_nettype wire

[hdl/ahct_ctrl.sv]
// Controller of the connection table: clearing pass, start-slot reduction, probe
`default_nettype none
module ahct_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ahct_pkg::dp_stat_t stat,
    output logic                   busy,
    output ahct_pkg::dp_cmd_t      cmd
);
    import ahct_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_SEED  = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;

    // quotient, then remainder
    localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(1);

    logic [2:0]           state_reg, state_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            mod_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mod_cnt_reg <= mod_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mod_cnt_next = mod_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    mod_cnt_next = '0;
                    state_next   = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == MOD_LAST)
                    state_next = S_SEED;
            end
            S_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                cmd.probe = 1'b1;
                if (stat.probe_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

[hdl/ahct_datapath.sv]
// Datapath of the connection table: slot memories, modulo unit, probe evaluation
`default_nettype none
module ahct_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ahct_pkg::dp_cmd_t               cmd,
    output ahct_pkg::dp_stat_t                   stat,
    input  wire logic                            cfg_we,
    input  wire logic [ahct_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  wire logic                            command,
    input  wire logic [ahct_pkg::KEY_ADDR_W-1:0] key_addr,
    input  wire logic [ahct_pkg::KEY_PORT_W-1:0] key_port,
    input  wire logic [ahct_pkg::SEQ_W-1:0]      seq_in,
    input  wire logic [ahct_pkg::TICK_W-1:0]     now,
    output logic                                 done,
    output logic [ahct_pkg::STATUS_W-1:0]        status,
    output logic [ahct_pkg::SEQ_W-1:0]           seq_out
);
    import ahct_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int MUL_W     = KEY_PORT_W + 1;
    localparam int PROD_W    = KEY_PORT_W + MUL_W;
    localparam int DIV_SHIFT = KEY_PORT_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [MUL_W-1:0] DEPTH_MUL = MUL_W'(TABLE_DEPTH);
    localparam logic [MUL_W-1:0] RECIP     =
        MUL_W'(((64'd1 << DIV_SHIFT) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));

    logic   valid_mem [TABLE_DEPTH];
    entry_t entry_mem [TABLE_DEPTH];

    logic                  cmd_reg;
    logic [KEY_ADDR_W-1:0] addr_reg;
    logic [KEY_PORT_W-1:0] port_reg;
    logic [SEQ_W-1:0]      seq_reg;
    logic [TICK_W-1:0]     now_reg;
    logic [LIMIT_W-1:0]    age_limit_reg;

    logic [KEY_PORT_W-1:0] quot_reg;
    logic [IDX_W-1:0]      rem_reg;
    logic [PROD_W-1:0]     quot_prod, back_prod;
    logic [IDX_W-1:0]      rem_diff;

    logic [IDX_W-1:0] start_reg, rd_ptr_reg, ev_ptr_reg, rd_ptr_inc, ev_ptr_inc;
    logic             ev_valid_reg;
    logic             valid_q_reg;
    entry_t           entry_q_reg;

    logic             done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SEQ_W-1:0] seq_out_reg;

    logic [TICK_W-1:0]   age;
    logic                expired, match, wrap;
    logic                vwe, vwd, ewe, fin;
    logic [IDX_W-1:0]    vwaddr;
    logic [STATUS_W-1:0] fst;
    logic [SEQ_W-1:0]    fseq;
    entry_t              new_entry;

    assign rd_ptr_inc = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
    assign ev_ptr_inc = (ev_ptr_reg == LAST_IDX) ? '0 : ev_ptr_reg + 1'b1;

    // start slot by reciprocal multiply: quotient step, then remainder step
    assign quot_prod = {{MUL_W{1'b0}}, port_reg} * {{KEY_PORT_W{1'b0}}, RECIP};
    assign back_prod = {{MUL_W{1'b0}}, quot_reg} * {{KEY_PORT_W{1'b0}}, DEPTH_MUL};
    assign rem_diff  = IDX_W'({{MUL_W{1'b0}}, port_reg} - back_prod);

    assign age     = now_reg - entry_q_reg.stamp;
    assign expired = age[TICK_W-1] | (age[LIMIT_W-1:0] > age_limit_reg);
    assign match   = (entry_q_reg.addr == addr_reg) && (entry_q_reg.port == port_reg);
    assign wrap    = (ev_ptr_inc == start_reg);

    assign new_entry.addr  = addr_reg;
    assign new_entry.port  = port_reg;
    assign new_entry.seq   = seq_reg;
    assign new_entry.stamp = now_reg;

    always_comb
    begin
        vwe    = 1'b0;
        vwd    = 1'b0;
        ewe    = 1'b0;
        fin    = 1'b0;
        fst    = ST_STORED;
        fseq   = '0;
        vwaddr = ev_ptr_reg;
        if (cmd.clear_step)
        begin
            vwe    = 1'b1;
            vwaddr = rd_ptr_reg;
        end
        else if (cmd.probe && ev_valid_reg)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                if (!valid_q_reg)
                begin
                    vwe = 1'b1;
                    vwd = 1'b1;
                    ewe = 1'b1;
                    fin = 1'b1;
                    fst = ST_STORED;
                end
                else
                begin
                    vwe = expired;
                    if (wrap)
                    begin
                        fin = 1'b1;
                        fst = ST_FULL;
                    end
                end
            end
            else
            begin
                if (valid_q_reg && match)
                begin
                    vwe  = 1'b1;
                    fin  = 1'b1;
                    fst  = ST_FOUND;
                    fseq = entry_q_reg.seq;
                end
                else
                begin
                    vwe = valid_q_reg && expired;
                    if (wrap)
                    begin
                        fin = 1'b1;
                        fst = ST_NOT_FOUND;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
            valid_mem[vwaddr] <= vwd;
        valid_q_reg <= valid_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ewe)
            entry_mem[ev_ptr_reg] <= new_entry;
        entry_q_reg <= entry_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= command;
            addr_reg <= key_addr;
            port_reg <= key_port;
            seq_reg  <= seq_in;
            now_reg  <= now;
        end
        else if (cmd.mod_step)
        begin
            quot_reg <= KEY_PORT_W'(quot_prod >> DIV_SHIFT);
            rem_reg  <= rem_diff;
        end
        if (cmd.seed)
            start_reg <= rem_reg;
        if (cmd.probe)
            ev_ptr_reg <= rd_ptr_reg;
        if (fin)
        begin
            status_reg  <= fst;
            seq_out_reg <= fseq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= LIMIT_W'(10);
            rd_ptr_reg    <= '0;
            ev_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                age_limit_reg <= cfg_wdata;
            if (cmd.seed)
            begin
                rd_ptr_reg   <= rem_reg;
                ev_valid_reg <= 1'b0;
            end
            else if (cmd.clear_step)
                rd_ptr_reg <= rd_ptr_inc;
            else if (cmd.probe)
            begin
                rd_ptr_reg   <= rd_ptr_inc;
                ev_valid_reg <= 1'b1;
            end
            done_reg <= fin;
        end
    end

    assign stat.clear_last = (rd_ptr_reg == LAST_IDX);
    assign stat.probe_done = fin;

    assign done    = done_reg;
    assign status  = status_reg;
    assign seq_out = seq_out_reg;

endmodule
`default_nettype wire

[hdl/aging_hash_connection_table_unit.sv]
// Top level of the aging connection table unit
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  command  | start, busy         | command, key_addr, key_port, seq_in, now
//  result   | done (one cycle)    | status, seq_out
//  config   | cfg_we              | cfg_wdata (age limit)
//
// After reset a clearing pass over all TABLE_DEPTH slots runs with busy high.
// Each transfer reduces key_port modulo the depth (quotient by reciprocal
// multiply, then remainder), seeds the read pointer with the start slot, then
// walks one slot per cycle through the read-evaluate-write probe of the slot
// memories, whose reads are registered.
// The result is registered and shown for one cycle; it cannot be stalled.
`default_nettype none
module aging_hash_connection_table_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            command,
    input  wire logic [ahct_pkg::KEY_ADDR_W-1:0] key_addr,
    input  wire logic [ahct_pkg::KEY_PORT_W-1:0] key_port,
    input  wire logic [ahct_pkg::SEQ_W-1:0]      seq_in,
    input  wire logic [ahct_pkg::TICK_W-1:0]     now,
    input  wire logic                            cfg_we,
    input  wire logic [ahct_pkg::LIMIT_W-1:0]    cfg_wdata,
    output logic                                 done,
    output logic [ahct_pkg::STATUS_W-1:0]        status,
    output logic [ahct_pkg::SEQ_W-1:0]           seq_out
);
    import ahct_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    ahct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .busy  (busy),
        .cmd   (dp_cmd)
    );

    ahct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .command   (command),
        .key_addr  (key_addr),
        .key_port  (key_port),
        .seq_in    (seq_in),
        .now       (now),
        .done      (done),
        .status    (status),
        .seq_out   (seq_out)
    );

endmodule
`default_nettype wire

[hdl/ahct_checker.sv]
// Port-level checker of the connection table unit and its bind
`default_nettype none
`include "aging_hash_connection_table_unit_assert.svh"
module ahct_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [ahct_pkg::STATUS_W-1:0] status,
    input wire logic [ahct_pkg::SEQ_W-1:0]    seq_out
);
    import ahct_pkg::*;

    `AHCT_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `AHCT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `AHCT_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `AHCT_ASSERT_NOW(a_seq_zero, clk, rst_n, done && (status != ST_FOUND), seq_out == '0)

endmodule

bind aging_hash_connection_table_unit ahct_checker u_ahct_checker (.*);
`default_nettype wire

[test/tb_aging_hash_connection_table_unit.sv]
// Testbench for the aging connection table unit: directed and random transfers
module tb_aging_hash_connection_table_unit;
    import ahct_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int unsigned CYCLE_LIMIT = 8_000_000;

    typedef struct packed {
        logic                  cmd;
        logic [KEY_ADDR_W-1:0] addr;
        logic [KEY_PORT_W-1:0] port;
        logic [SEQ_W-1:0]      seq;
        logic [TICK_W-1:0]     tick;
    } table_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SEQ_W-1:0]    seq;
    } outcome_t;

    typedef struct packed {
        logic [KEY_ADDR_W-1:0] addr;
        logic [KEY_PORT_W-1:0] port;
    } conn_key_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  command = CMD_INSERT;
    logic [KEY_ADDR_W-1:0] key_addr = '0;
    logic [KEY_PORT_W-1:0] key_port = '0;
    logic [SEQ_W-1:0]      seq_in = '0;
    logic [TICK_W-1:0]     now = '0;
    logic                  cfg_we = 1'b0;
    logic [LIMIT_W-1:0]    cfg_wdata = '0;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [SEQ_W-1:0]      seq_out;

    // predictor state
    bit                    slot_valid [TABLE_DEPTH];
    logic [KEY_ADDR_W-1:0] slot_addr  [TABLE_DEPTH];
    logic [KEY_PORT_W-1:0] slot_port  [TABLE_DEPTH];
    logic [SEQ_W-1:0]      slot_seq   [TABLE_DEPTH];
    logic [TICK_W-1:0]     slot_stamp [TABLE_DEPTH];
    logic [LIMIT_W-1:0]    age_lim = 15'd10;

    table_op_t   pending_ops[$];
    outcome_t    expected_outcomes[$];
    conn_key_t   live_keys[$];
    table_op_t   next_op;
    outcome_t    predicted;
    outcome_t    oldest;
    logic        xfer_seen = 1'b0;
    logic        idle_seen = 1'b0;
    int          gap_pct = 17;
    int          fail_count = 0;
    int unsigned cycle_count = 0;
    logic [TICK_W-1:0] tick_now = '0;

    aging_hash_connection_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .command  (command),
        .key_addr (key_addr),
        .key_port (key_port),
        .seq_in   (seq_in),
        .now      (now),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .done     (done),
        .status   (status),
        .seq_out  (seq_out)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic bit aged_out(input int unsigned idx, input logic [TICK_W-1:0] tnow);
        logic [TICK_W-1:0] age;
        age = tnow - slot_stamp[idx];
        return age[TICK_W-1] || (age > {1'b0, age_lim});
    endfunction

    task automatic probe_table(input table_op_t op, output outcome_t res);
        int unsigned first;
        int unsigned idx;
        bit          stop;
        first = op.port % TABLE_DEPTH;
        idx = first;
        stop = 1'b0;
        res.seq = '0;
        if (op.cmd == CMD_INSERT)
        begin
            res.status = ST_STORED;
            while (slot_valid[idx] && !stop)
            begin
                if (aged_out(idx, op.tick))
                    slot_valid[idx] = 1'b0;
                idx = (idx + 1) % TABLE_DEPTH;
                if (idx == first)
                begin
                    res.status = ST_FULL;
                    stop = 1'b1;
                end
            end
            if (!stop)
            begin
                slot_addr[idx]  = op.addr;
                slot_port[idx]  = op.port;
                slot_seq[idx]   = op.seq;
                slot_stamp[idx] = op.tick;
                slot_valid[idx] = 1'b1;
            end
        end
        else
        begin
            res.status = ST_NOT_FOUND;
            for (int n = 0; n < TABLE_DEPTH && !stop; n++)
            begin
                idx = (first + n) % TABLE_DEPTH;
                if (slot_valid[idx])
                begin
                    if (slot_addr[idx] == op.addr && slot_port[idx] == op.port)
                    begin
                        slot_valid[idx] = 1'b0;
                        res.status = ST_FOUND;
                        res.seq = slot_seq[idx];
                        stop = 1'b1;
                    end
                    else if (aged_out(idx, op.tick))
                    begin
                        slot_valid[idx] = 1'b0;
                    end
                end
            end
        end
    endtask

    // driver: one transfer per start/!busy edge
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || xfer_seen)
        begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                next_op = pending_ops.pop_front();
                command  <= next_op.cmd;
                key_addr <= next_op.addr;
                key_port <= next_op.port;
                seq_in   <= next_op.seq;
                now      <= next_op.tick;
                start    <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        xfer_seen = rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("unexpected result: status %0d, seq_out %h", status, seq_out);
                fail_count++;
            end
            else
            begin
                oldest = expected_outcomes.pop_front();
                if (status !== oldest.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest.status, status);
                    fail_count++;
                end
                if (seq_out !== oldest.seq)
                begin
                    $error("seq_out: expected %h, actual %h", oldest.seq, seq_out);
                    fail_count++;
                end
            end
        end
        if (xfer_seen)
        begin
            probe_table('{command, key_addr, key_port, seq_in, now}, predicted);
            expected_outcomes.push_back(predicted);
        end
        idle_seen = rst_n && pending_ops.size() == 0 && !start
                    && expected_outcomes.size() == 0 && !busy;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_op(input logic cmd, input logic [KEY_ADDR_W-1:0] addr,
                            input logic [KEY_PORT_W-1:0] port, input logic [SEQ_W-1:0] seq,
                            input logic [TICK_W-1:0] tick);
        table_op_t op;
        op.cmd = cmd;
        op.addr = addr;
        op.port = port;
        op.seq = seq;
        op.tick = tick;
        pending_ops.push_back(op);
    endtask

    task automatic drain();
        @(posedge clk);
        do
            @(negedge clk);
        while (!idle_seen);
    endtask

    // called at a falling edge with the block idle; ops are queued after cfg_we is dropped
    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        age_lim = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int unsigned       win;
        int unsigned       c;
        int unsigned       k;
        logic              cmd;
        logic [KEY_ADDR_W-1:0] addr;
        logic [KEY_PORT_W-1:0] port;
        conn_key_t         key;
        win = $urandom_range(0, TABLE_DEPTH - 1);
        repeat (count)
        begin
            if ($urandom_range(99) < 3)
                tick_now = TICK_W'($urandom);
            else
                tick_now = tick_now + TICK_W'($urandom_range(0, 3));
            if ($urandom_range(9) == 0)
                port = KEY_PORT_W'($urandom);
            else
                port = KEY_PORT_W'((win + $urandom_range(0, 23)) % TABLE_DEPTH
                                   + TABLE_DEPTH * $urandom_range(0, 63));
            addr = $urandom;
            cmd = CMD_INSERT;
            c = $urandom_range(99);
            if (c >= 50 && c < 90 && live_keys.size() != 0)
            begin
                k = $urandom_range(0, live_keys.size() - 1);
                addr = live_keys[k].addr;
                port = live_keys[k].port;
                if (c >= 60)
                begin
                    cmd = CMD_LOOKUP;
                    live_keys.delete(k);
                end
            end
            else if (c >= 90)
                cmd = CMD_LOOKUP;
            else if (c < 50)
            begin
                key.addr = addr;
                key.port = port;
                live_keys.push_back(key);
                if (live_keys.size() > 64)
                    void'(live_keys.pop_front());
            end
            queue_op(cmd, addr, port, $urandom, tick_now);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed, reset age limit of 10
        queue_op(CMD_INSERT, 32'h0, 16'h0, 32'h0, 16'h0);
        queue_op(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        queue_op(CMD_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'hFFFF);
        queue_op(CMD_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'hFFFF);
        // collision chain
        queue_op(CMD_INSERT, 32'h0A00_0001, 16'd5, 32'h11, 16'd100);
        queue_op(CMD_INSERT, 32'h0A00_0002, 16'd1029, 32'h22, 16'd100);
        queue_op(CMD_INSERT, 32'h0A00_0003, 16'd6, 32'h33, 16'd100);
        queue_op(CMD_LOOKUP, 32'h0A00_0003, 16'd6, 32'h0, 16'd105);
        // key match beats expiry
        queue_op(CMD_LOOKUP, 32'h0A00_0002, 16'd1029, 32'h0, 16'd200);
        // slots cleared by an insert are skipped
        queue_op(CMD_INSERT, 32'hC0A8_0001, 16'd20, 32'h44, 16'd300);
        queue_op(CMD_INSERT, 32'hC0A8_0002, 16'd20, 32'h55, 16'd300);
        queue_op(CMD_INSERT, 32'hC0A8_0003, 16'd20, 32'h66, 16'd400);
        queue_op(CMD_LOOKUP, 32'hC0A8_0003, 16'd20, 32'h0, 16'd400);
        // negative age
        queue_op(CMD_INSERT, 32'h7F00_0001, 16'd30, 32'h77, 16'd1000);
        queue_op(CMD_INSERT, 32'h7F00_0002, 16'd30, 32'h88, 16'd990);
        queue_op(CMD_LOOKUP, 32'h7F00_0001, 16'd30, 32'h0, 16'd990);
        queue_op(CMD_LOOKUP, 32'h7F00_0002, 16'd30, 32'h0, 16'd990);
        // age equal to the limit is kept, one more is dropped
        queue_op(CMD_INSERT, 32'h0808_0808, 16'd40, 32'h99, 16'd2000);
        queue_op(CMD_LOOKUP, 32'h0808_0404, 16'd40, 32'h0, 16'd2010);
        queue_op(CMD_LOOKUP, 32'h0808_0808, 16'd40, 32'h0, 16'd2010);
        queue_op(CMD_INSERT, 32'h0102_0304, 16'd50, 32'hAA, 16'd3000);
        queue_op(CMD_LOOKUP, 32'h0403_0201, 16'd50, 32'h0, 16'd3011);
        queue_op(CMD_LOOKUP, 32'h0102_0304, 16'd50, 32'h0, 16'd3011);
        drain();

        tick_now = TICK_W'($urandom);
        set_limit(LIMIT_W'($urandom_range(4, 40)));
        random_phase(139);
        drain();

        gap_pct = 86;
        set_limit(15'd0);
        random_phase(139);
        drain();

        gap_pct = 0;
        set_limit(LIMIT_W'($urandom_range(200, 5000)));
        random_phase(139);
        drain();

        set_limit(LIMIT_W'($urandom_range(1, 20)));
        random_phase(139);
        drain();

        repeat (40) @(posedge clk);
        if (fail_count == 0 && expected_outcomes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
